// ----- rtl/core/fa_clock_pkg.sv -----
// shared types and codes for the clock replacement frame allocator
// no dependencies
`default_nettype none
package fa_clock_pkg;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_REF     = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_EVICT = 2'd1,
        ST_NONE  = 2'd2,
        ST_DONE  = 2'd3
    } t_status;

    // flag memory entry: bit 1 ring member, bit 0 reference
    localparam logic [1:0] FL_CLEAR  = 2'b00;
    localparam logic [1:0] FL_IN     = 2'b10;
    localparam logic [1:0] FL_IN_REF = 2'b11;

    typedef enum logic [1:0] {
        NS_HAND  = 2'd0,
        NS_CUR   = 2'd1,
        NS_FRAME = 2'd2
    } t_nsel;

    typedef enum logic {
        FS_FRAME = 1'b0,
        FS_NXQ   = 1'b1
    } t_fsel;

    typedef struct packed {
        logic    latch;
        t_nsel   nx_sel;
        t_fsel   fl_sel;
        logic    clr;
        logic    pop;
        logic    ins_a;
        logic    ins_b;
        logic    ins_fin;
        logic    ev_clr;
        logic    ev_pick;
        logic    ev_unlink;
        logic    rel_start;
        logic    rel_step;
        logic    rel_fin;
        logic    ref_set;
        logic    emit;
        t_status emit_st;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       clr_last;
        logic       free_zero;
        logic       used_zero;
        logic       member;
        logic       ref_hit;
        logic       nx_is_frame;
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- rtl/core/fa_clock_ctrl.sv -----
// sequencing state machine for the frame allocator
// depends on fa_clock_pkg
`default_nettype none
module fa_clock_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  fa_clock_pkg::t_dp_stat     i_stat,
    output fa_clock_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [17:0] {
        S_CLR   = 18'b000000000000000001,
        S_IDLE  = 18'b000000000000000010,
        S_DISP  = 18'b000000000000000100,
        S_POP   = 18'b000000000000001000,
        S_INS   = 18'b000000000000010000,
        S_INS2  = 18'b000000000000100000,
        S_ERD   = 18'b000000000001000000,
        S_ECHK  = 18'b000000000010000000,
        S_EWAIT = 18'b000000000100000000,
        S_VRD   = 18'b000000001000000000,
        S_VW    = 18'b000000010000000000,
        S_VWAIT = 18'b000000100000000000,
        S_LCHK  = 18'b000001000000000000,
        S_LWAIT = 18'b000010000000000000,
        S_LRD   = 18'b000100000000000000,
        S_LFR   = 18'b001000000000000000,
        S_LFW   = 18'b010000000000000000,
        S_RCHK  = 18'b100000000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_evict, n_evict;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_evict = r_evict;
        o_cmd = '0;
        o_cmd.nx_sel = fa_clock_pkg::NS_HAND;
        o_cmd.fl_sel = fa_clock_pkg::FS_FRAME;
        o_cmd.emit_st = fa_clock_pkg::ST_DONE;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                priority if (i_stat.kind == fa_clock_pkg::KIND_ALLOC) begin
                    priority if (!i_stat.free_zero) begin
                        n_evict = 1'b0;
                        n_state = S_POP;
                    end else if (!i_stat.used_zero) begin
                        n_evict = 1'b1;
                        n_state = S_ERD;
                    end else begin
                        o_cmd.emit = 1'b1;
                        o_cmd.emit_st = fa_clock_pkg::ST_NONE;
                        n_state = S_IDLE;
                    end
                end else if (i_stat.kind == fa_clock_pkg::KIND_REF) begin
                    n_state = S_RCHK;
                end else if (i_stat.kind == fa_clock_pkg::KIND_RELEASE) begin
                    n_state = S_LCHK;
                end else begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state = S_INS;
            end
            S_INS: begin
                o_cmd.ins_a = 1'b1;
                if (i_stat.used_zero) begin
                    o_cmd.ins_fin = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_st = r_evict ? fa_clock_pkg::ST_EVICT : fa_clock_pkg::ST_FREE;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_INS2;
                end
            end
            S_INS2: begin
                o_cmd.ins_b = 1'b1;
                o_cmd.ins_fin = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.emit_st = r_evict ? fa_clock_pkg::ST_EVICT : fa_clock_pkg::ST_FREE;
                n_state = S_IDLE;
            end
            S_ERD: begin
                o_cmd.fl_sel = fa_clock_pkg::FS_NXQ;
                n_state = S_ECHK;
            end
            S_ECHK: begin
                if (i_stat.ref_hit) begin
                    o_cmd.ev_clr = 1'b1;
                    n_state = S_EWAIT;
                end else begin
                    o_cmd.ev_pick = 1'b1;
                    n_state = S_VRD;
                end
            end
            S_EWAIT: n_state = S_ERD;
            S_VRD: begin
                o_cmd.nx_sel = fa_clock_pkg::NS_CUR;
                n_state = S_VW;
            end
            S_VW: begin
                o_cmd.ev_unlink = 1'b1;
                n_state = S_VWAIT;
            end
            S_VWAIT: n_state = S_INS;
            S_LCHK: begin
                if (i_stat.member) begin
                    o_cmd.rel_start = 1'b1;
                    n_state = S_LWAIT;
                end else begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LWAIT: begin
                o_cmd.nx_sel = fa_clock_pkg::NS_CUR;
                n_state = S_LRD;
            end
            S_LRD: begin
                o_cmd.nx_sel = fa_clock_pkg::NS_CUR;
                if (i_stat.nx_is_frame) begin
                    n_state = S_LFR;
                end else begin
                    o_cmd.rel_step = 1'b1;
                    n_state = S_LWAIT;
                end
            end
            S_LFR: begin
                o_cmd.nx_sel = fa_clock_pkg::NS_FRAME;
                n_state = S_LFW;
            end
            S_LFW: begin
                o_cmd.rel_fin = 1'b1;
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            S_RCHK: begin
                o_cmd.ref_set = i_stat.member;
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_evict <= 1'b0;
        end else begin
            r_state <= n_state;
            r_evict <= n_evict;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/fa_clock_dp.sv -----
// datapath of the frame allocator: free fifo, ring links, flags, counters
// depends on fa_clock_pkg
`default_nettype none
module fa_clock_dp #(
    parameter int NUM_FRAMES = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [1:0]            i_kind,
    input  wire logic [9:0]            i_frame,
    input  fa_clock_pkg::t_dp_cmd      i_cmd,
    output fa_clock_pkg::t_dp_stat     o_stat,
    output logic                       o_strobe,
    output logic [9:0]                 o_frame_out,
    output logic [1:0]                 o_status,
    output logic [10:0]                o_free_count
);

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int XW = (CW > 11) ? CW : 11;
    localparam logic [FW-1:0] LAST = FW'(NUM_FRAMES - 1);
    localparam logic [CW-1:0] FULL = CW'(NUM_FRAMES);

    logic [FW-1:0] r_nx_mem [NUM_FRAMES];
    logic [1:0]    r_fl_mem [NUM_FRAMES];
    logic [FW-1:0] r_ff_mem [NUM_FRAMES];
    logic [FW-1:0] r_nx_q, r_ff_q;
    logic [1:0]    r_fl_q;

    logic [FW-1:0] r_head, r_tail, r_hand, r_cur, r_clr;
    logic [CW-1:0] r_total, r_used, r_fill;
    logic [FW-1:0] n_head, n_tail, n_hand, n_cur, n_clr;
    logic [CW-1:0] n_total, n_used, n_fill;
    logic [9:0]    r_frame;
    logic [1:0]    r_kind;

    logic [FW-1:0] frame_a, nx_ra, nx_wa, nx_wd, fl_ra, fl_wa, pop_val;
    logic [1:0]    fl_wd;
    logic          nx_we, fl_we, ff_we, in_range;

    assign frame_a  = FW'(r_frame);
    assign in_range = XW'(r_frame) < XW'(NUM_FRAMES);
    assign pop_val  = (CW'(r_head) < r_fill) ? r_ff_q : r_head;

    always_comb begin
        unique case (i_cmd.nx_sel)
            fa_clock_pkg::NS_CUR:   nx_ra = r_cur;
            fa_clock_pkg::NS_FRAME: nx_ra = frame_a;
            default:                nx_ra = r_hand;
        endcase
        fl_ra = (i_cmd.fl_sel == fa_clock_pkg::FS_NXQ) ? r_nx_q : frame_a;

        nx_we = 1'b0;
        nx_wa = r_cur;
        nx_wd = r_nx_q;
        priority if (i_cmd.ins_a) begin
            nx_we = 1'b1;
            nx_wd = (r_used == '0) ? r_cur : r_nx_q;
        end else if (i_cmd.ins_b) begin
            nx_we = 1'b1;
            nx_wa = r_hand;
            nx_wd = r_cur;
        end else if (i_cmd.ev_unlink) begin
            nx_we = 1'b1;
            nx_wa = r_hand;
        end else if (i_cmd.rel_fin) begin
            nx_we = 1'b1;
        end

        fl_we = 1'b1;
        fl_wa = r_cur;
        fl_wd = fa_clock_pkg::FL_CLEAR;
        priority if (i_cmd.clr) begin
            fl_wa = r_clr;
        end else if (i_cmd.ins_a) begin
            fl_wd = fa_clock_pkg::FL_IN;
        end else if (i_cmd.ev_clr) begin
            fl_wa = r_nx_q;
            fl_wd = fa_clock_pkg::FL_IN;
        end else if (i_cmd.ev_unlink) begin
            fl_wa = r_cur;
        end else if (i_cmd.rel_fin) begin
            fl_wa = frame_a;
        end else if (i_cmd.ref_set) begin
            fl_wa = frame_a;
            fl_wd = fa_clock_pkg::FL_IN_REF;
        end else begin
            fl_we = 1'b0;
        end

        ff_we = i_cmd.rel_fin && (r_total != FULL);

        n_head  = r_head;
        n_tail  = r_tail;
        n_total = r_total;
        n_fill  = r_fill;
        n_hand  = r_hand;
        n_used  = r_used;
        n_cur   = r_cur;
        n_clr   = r_clr;
        if (i_cmd.clr) n_clr = r_clr + 1'b1;
        if (i_cmd.pop) begin
            n_cur   = pop_val;
            n_head  = (r_head == LAST) ? '0 : r_head + 1'b1;
            n_total = r_total - 1'b1;
        end
        if (i_cmd.ins_fin) begin
            n_hand = r_cur;
            n_used = r_used + 1'b1;
        end
        if (i_cmd.ev_clr) n_hand = r_nx_q;
        if (i_cmd.ev_pick || i_cmd.rel_step) n_cur = r_nx_q;
        if (i_cmd.ev_unlink) n_used = r_used - 1'b1;
        if (i_cmd.rel_start) n_cur = r_hand;
        if (i_cmd.rel_fin) begin
            n_used = r_used - 1'b1;
            if (frame_a == r_hand) n_hand = r_cur;
        end
        if (ff_we) begin
            n_tail  = (r_tail == LAST) ? '0 : r_tail + 1'b1;
            n_total = r_total + 1'b1;
            if (CW'(r_tail) == r_fill) n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) r_nx_mem[nx_wa] <= nx_wd;
        r_nx_q <= r_nx_mem[nx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) r_fl_mem[fl_wa] <= fl_wd;
        r_fl_q <= r_fl_mem[fl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ff_we) r_ff_mem[r_tail] <= frame_a;
        r_ff_q <= r_ff_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_total  <= FULL;
            r_fill   <= '0;
            r_hand   <= '0;
            r_used   <= '0;
            r_clr    <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_total  <= n_total;
            r_fill   <= n_fill;
            r_hand   <= n_hand;
            r_used   <= n_used;
            r_clr    <= n_clr;
            o_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (i_cmd.latch) begin
            r_kind  <= i_kind;
            r_frame <= i_frame;
        end
        if (i_cmd.emit) begin
            o_status     <= i_cmd.emit_st;
            o_free_count <= 11'(n_total);
            unique case (i_cmd.emit_st)
                fa_clock_pkg::ST_FREE,
                fa_clock_pkg::ST_EVICT: o_frame_out <= 10'(r_cur);
                fa_clock_pkg::ST_NONE:  o_frame_out <= '0;
                default:                o_frame_out <= r_frame;
            endcase
        end
    end

    assign o_stat.kind        = r_kind;
    assign o_stat.clr_last    = (r_clr == LAST);
    assign o_stat.free_zero   = (r_total == '0);
    assign o_stat.used_zero   = (r_used == '0);
    assign o_stat.member      = in_range && r_fl_q[1];
    assign o_stat.ref_hit     = r_fl_q[0];
    assign o_stat.nx_is_frame = (r_nx_q == frame_a);

    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (((CW+1)'(r_total) + (CW+1)'(r_used)) == (CW+1)'(NUM_FRAMES)))
        else $error("free and ring counts do not add up");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("fifo fill count overrun");
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == fa_clock_pkg::ST_NONE) |-> (o_free_count == '0))
        else $error("no frame reported while frames are free");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_total != '0))
        else $error("pop from empty free list");

endmodule
`default_nettype wire

// ----- rtl/core/frame_allocator_clock_replacement.sv -----
// top level of the clock replacement frame allocator
// free path pops the free fifo into the ring; eviction sweeps from the hand, clearing
// reference bits, then reuses an unreferenced frame; release unlinks and frees the frame
// one transaction at a time, busy high meanwhile, next accepted as the strobe ends
// reset runs a flag clearing pass over all NUM_FRAMES entries, busy high during it
// results strobe for one cycle; the receiver cannot stall
`default_nettype none
module frame_allocator_clock_replacement #(
    parameter int NUM_FRAMES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [9:0]  i_frame,
    output logic             o_strobe,
    output logic [9:0]       o_frame_out,
    output logic [1:0]       o_status,
    output logic [10:0]      o_free_count
);

    fa_clock_pkg::t_dp_cmd  cmd;
    fa_clock_pkg::t_dp_stat stat;

    fa_clock_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fa_clock_dp #(.NUM_FRAMES(NUM_FRAMES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kind       (i_kind),
        .i_frame      (i_frame),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_strobe     (o_strobe),
        .o_frame_out  (o_frame_out),
        .o_status     (o_status),
        .o_free_count (o_free_count)
    );

endmodule
`default_nettype wire
